/* rtl/e2g_pkg.sv */
package e2g_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int FRACTION_BITS_DEF = 10;

    // field widths
    localparam int POS_W     = 35;
    localparam int ANGLE_W   = 32;
    localparam int HEIGHT_W  = 35;
    localparam int S_TDATA_W = 112;  // 3 x 35 bits, padded to bytes
    localparam int M_TDATA_W = 104;  // 32 + 32 + 35 bits, padded to bytes

    // internal widths
    localparam int GUARD_BITS = 14;
    localparam int AW         = 34;  // angle accumulator, headroom past a half turn
    localparam int CW         = 33;  // Q30 coefficient operand of the multipliers
    localparam int SQ_W       = 62;  // square root radicand / root
    localparam int SQ_STEPS   = 31;  // one root bit per cell

    localparam longint Q30_ONE       = 64'sd1073741824;
    localparam longint INV_GAIN_Q30  = 64'sd652032874;
    localparam longint B_OVER_A_Q30  = 64'sd1070141771;
    localparam longint E2_Q30        = 64'sd7188036;
    localparam longint EP2_Q30       = 64'sd7236480;
    localparam longint SEMI_MAJOR_M  = 64'sd6378137;
    localparam longint QUARTER_TURN  = 64'sd1073741824;
    localparam longint ANGLE_PER_RAD = 64'sd683565276;
    localparam longint HEIGHT_MAX    = 64'sd17179869183;
    localparam longint HEIGHT_MIN    = -64'sd17179869184;

    // atan(2^-i) in units of pi/2^31, rounded
    function automatic longint step_angle(int i);
        longint first [10];
        first = '{64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
                  64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
                  64'sd2670163, 64'sd1335087};
        if (i < 10) begin
            return first[i];
        end
        return (ANGLE_PER_RAD + (64'sd1 <<< (i - 1))) >>> i;
    endfunction

endpackage

/* rtl/ecef_to_geodetic_convert.sv */
// ECEF to geodetic (WGS84, Bowring single step).
// Input stream s_*: one beat per position, x/y/z in metres * 2^FRACTION_BITS.
// Output stream m_*: one beat per position: latitude and longitude in units of
// pi/2^31 rad, height above the ellipsoid in metres * 2^FRACTION_BITS, and a
// degenerate flag in m_tuser (on the polar axis, or height saturated).
// On the polar axis longitude is 0, latitude is +-quarter turn (0 at origin)
// and height is |z| - b.
// Five CORDIC chains, the 31-cell square root and the two-stage multipliers
// set the depth of the pipeline.
// Throughput is one beat per cycle while the receiver does not stall; every
// stage is a register row that advances together.
// When the receiver stalls with a result held on m_*, the whole pipeline
// freezes and s_tready drops until the beat is taken.
// aresetn (synchronous, active low) clears all valid bits; data in flight
// is dropped.
module ecef_to_geodetic_convert
    import e2g_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_pos[34:0], y_pos[69:35], z_pos[104:70]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // latitude[31:0], longitude[63:32], height[98:64]
    output logic                 m_tuser    // degenerate
);

    localparam int W  = (FRACTION_BITS + 40 > 52) ? FRACTION_BITS + 40 : 52;
    localparam int HW = W + 2;

    localparam logic signed [127:0] A_WIDE   = 128'(SEMI_MAJOR_M) <<< (FRACTION_BITS + GUARD_BITS);
    localparam logic signed [127:0] B_WIDE   = (A_WIDE * 128'(B_OVER_A_Q30)) >>> 30;
    localparam logic signed [127:0] BEP_WIDE = (B_WIDE * 128'(EP2_Q30)) >>> 30;
    localparam logic signed [127:0] AE2_WIDE = (A_WIDE * 128'(E2_Q30)) >>> 30;
    localparam logic signed [W-1:0] A_INT    = A_WIDE[W-1:0];
    localparam logic signed [W-1:0] B_INT    = B_WIDE[W-1:0];
    localparam logic signed [W-1:0] BEP      = BEP_WIDE[W-1:0];
    localparam logic signed [W-1:0] AE2      = AE2_WIDE[W-1:0];

    localparam logic signed [CW-1:0] INV_GAIN_C = CW'(INV_GAIN_Q30);
    localparam logic signed [CW-1:0] B_OVER_A_C = CW'(B_OVER_A_Q30);
    localparam logic signed [CW-1:0] E2_C       = CW'(E2_Q30);
    localparam logic signed [CW-1:0] Q30_C      = CW'(Q30_ONE);
    localparam logic signed [W-1:0]  INV_GAIN_W = W'(INV_GAIN_Q30);
    localparam logic signed [AW-1:0] QT         = AW'(QUARTER_TURN);
    localparam logic signed [HW-1:0] H_MAX      = HW'(HEIGHT_MAX);
    localparam logic signed [HW-1:0] H_MIN      = HW'(HEIGHT_MIN);
    localparam logic signed [HW-1:0] H_HALF     = HW'(1) <<< (GUARD_BITS - 1);

    // side bundles: SA = {polar, z}; SB = {polar, z, lon, p}
    localparam int SA = 1 + W;
    localparam int SB = SA + ANGLE_W + W;
    localparam int SE = SB + AW;
    localparam int SQS = SE + 2 * CW;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- input row
    logic                v0_reg, polar0_reg;
    logic signed [W-1:0] x0_reg, y0_reg, z0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg     <= W'($signed(s_tdata[34:0])) <<< GUARD_BITS;
            y0_reg     <= W'($signed(s_tdata[69:35])) <<< GUARD_BITS;
            z0_reg     <= W'($signed(s_tdata[104:70])) <<< GUARD_BITS;
            polar0_reg <= (s_tdata[34:0] == '0) && (s_tdata[69:35] == '0);
        end
    end

    // ---------------- longitude and horizontal distance
    logic                 va;
    logic signed [W-1:0]  xa, ya_unused;
    logic signed [AW-1:0] lona;
    logic [SA-1:0]        sidea;

    e2g_cordic_chain #(.W(W), .SIDE_W(SA), .STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_lon (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(v0_reg),
        .x_in(x0_reg), .y_in(y0_reg), .ang_in('0), .side_in({polar0_reg, z0_reg}),
        .out_valid(va), .x_out(xa), .y_out(ya_unused), .ang_out(lona), .side_out(sidea)
    );

    logic                v1;
    logic signed [W-1:0] p1;
    logic [SA+ANGLE_W-1:0] side1;

    e2g_mulq #(.W(W), .SIDE_W(SA + ANGLE_W)) u_gain (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(va),
        .v_in(xa), .c_in(INV_GAIN_C), .side_in({sidea, lona[ANGLE_W-1:0]}),
        .out_valid(v1), .prod_out(p1), .side_out(side1)
    );

    logic                v2;
    logic signed [W-1:0] pb;
    logic [SB-1:0]       side2;
    logic                polar2;
    logic signed [W-1:0] z2, p2;
    logic [ANGLE_W-1:0]  lon2;

    e2g_mulq #(.W(W), .SIDE_W(SB)) u_boa (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(v1),
        .v_in(p1), .c_in(B_OVER_A_C), .side_in({side1, p1}),
        .out_valid(v2), .prod_out(pb), .side_out(side2)
    );
    assign {polar2, z2, lon2, p2} = side2;

    // ---------------- parametric angle theta
    logic                 vb;
    logic signed [W-1:0]  xb_unused, yb_unused;
    logic signed [AW-1:0] thb;
    logic [SB-1:0]        sideb;

    e2g_cordic_chain #(.W(W), .SIDE_W(SB), .STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_theta (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(v2),
        .x_in(pb), .y_in(z2), .ang_in('0), .side_in(side2),
        .out_valid(vb), .x_out(xb_unused), .y_out(yb_unused), .ang_out(thb), .side_out(sideb)
    );

    logic                 vc;
    logic signed [W-1:0]  cth, sth;
    logic signed [AW-1:0] angc_unused;
    logic [SB-1:0]        sidec;

    e2g_cordic_chain #(.W(W), .SIDE_W(SB), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_sc_theta (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vb),
        .x_in(INV_GAIN_W), .y_in('0), .ang_in(thb), .side_in(sideb),
        .out_valid(vc), .x_out(cth), .y_out(sth), .ang_out(angc_unused), .side_out(sidec)
    );

    // ---------------- cubes of sin/cos theta
    logic                 vk1_reg, vk2_reg;
    logic signed [CW-1:0] s2_reg, c2_reg, sth_reg, cth_reg, s3_reg, c3_reg;
    logic [SB-1:0]        sidek1_reg, sidek2_reg;
    logic signed [2*CW-1:0] sq_s, sq_c, cu_s, cu_c;

    always_comb begin
        sq_s = $signed(sth[CW-1:0]) * $signed(sth[CW-1:0]);
        sq_c = $signed(cth[CW-1:0]) * $signed(cth[CW-1:0]);
        cu_s = s2_reg * sth_reg;
        cu_c = c2_reg * cth_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vk1_reg <= 1'b0;
            vk2_reg <= 1'b0;
        end else if (adv) begin
            vk1_reg <= vc;
            vk2_reg <= vk1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg     <= sq_s[CW+29:30];
            c2_reg     <= sq_c[CW+29:30];
            sth_reg    <= sth[CW-1:0];
            cth_reg    <= cth[CW-1:0];
            sidek1_reg <= sidec;
            s3_reg     <= cu_s[CW+29:30];
            c3_reg     <= cu_c[CW+29:30];
            sidek2_reg <= sidek1_reg;
        end
    end

    // ---------------- Bowring numerator and denominator
    logic                polark, polarn;
    logic signed [W-1:0] zk, pk, zn, pd, tn, td;
    logic [ANGLE_W-1:0]  lonk, lonn;
    logic                vn, vd_unused;

    assign {polark, zk, lonk, pk} = sidek2_reg;

    e2g_mulq #(.W(W), .SIDE_W(SA + ANGLE_W)) u_num (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vk2_reg),
        .v_in(BEP), .c_in(s3_reg), .side_in({polark, zk, lonk}),
        .out_valid(vn), .prod_out(tn), .side_out({polarn, zn, lonn})
    );

    e2g_mulq #(.W(W), .SIDE_W(W)) u_den (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vk2_reg),
        .v_in(AE2), .c_in(c3_reg), .side_in(pk),
        .out_valid(vd_unused), .prod_out(td), .side_out(pd)
    );

    logic                vs_reg;
    logic signed [W-1:0] num_reg, den_reg;
    logic [SB-1:0]       sides_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (adv) begin
            vs_reg <= vn;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg   <= zn + tn;
            den_reg   <= pd - td;
            sides_reg <= {polarn, zn, lonn, pd};
        end
    end

    // ---------------- latitude
    logic                 vd;
    logic signed [W-1:0]  xd_unused, yd_unused;
    logic signed [AW-1:0] latd;
    logic [SB-1:0]        sided;

    e2g_cordic_chain #(.W(W), .SIDE_W(SB), .STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_lat (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vs_reg),
        .x_in(den_reg), .y_in(num_reg), .ang_in('0), .side_in(sides_reg),
        .out_valid(vd), .x_out(xd_unused), .y_out(yd_unused), .ang_out(latd), .side_out(sided)
    );

    // deep inside the ellipsoid the denominator can go negative: clamp at the poles
    logic                 vl_reg;
    logic signed [AW-1:0] lat_reg, lat_next;
    logic [SB-1:0]        sidel_reg;

    always_comb begin
        lat_next = latd;
        if (latd > QT) begin
            lat_next = QT;
        end else if (latd < -QT) begin
            lat_next = -QT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
        end else if (adv) begin
            vl_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_reg   <= lat_next;
            sidel_reg <= sided;
        end
    end

    logic                 ve;
    logic signed [W-1:0]  clat, slat;
    logic signed [AW-1:0] ange_unused;
    logic [SE-1:0]        sidee;

    e2g_cordic_chain #(.W(W), .SIDE_W(SE), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_sc_lat (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vl_reg),
        .x_in(INV_GAIN_W), .y_in('0), .ang_in(lat_reg), .side_in({sidel_reg, lat_reg}),
        .out_valid(ve), .x_out(clat), .y_out(slat), .ang_out(ange_unused), .side_out(sidee)
    );

    // ---------------- w = 1 - e2 sin^2(lat)
    logic                   vw1_reg, vw2_reg;
    logic signed [CW-1:0]   s2e_reg, clat1_reg, slat1_reg, clat2_reg, slat2_reg, w_reg;
    logic signed [CW-1:0]   w_next;
    logic [SE-1:0]          sidew1_reg, sidew2_reg;
    logic signed [2*CW-1:0] sq_lat, e2_term;

    always_comb begin
        sq_lat  = $signed(slat[CW-1:0]) * $signed(slat[CW-1:0]);
        e2_term = s2e_reg * E2_C;
        w_next  = Q30_C - e2_term[CW+29:30];
        if (w_next[CW-1]) begin
            w_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw1_reg <= 1'b0;
            vw2_reg <= 1'b0;
        end else if (adv) begin
            vw1_reg <= ve;
            vw2_reg <= vw1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2e_reg    <= sq_lat[CW+29:30];
            clat1_reg  <= clat[CW-1:0];
            slat1_reg  <= slat[CW-1:0];
            sidew1_reg <= sidee;
            w_reg      <= w_next;
            clat2_reg  <= clat1_reg;
            slat2_reg  <= slat1_reg;
            sidew2_reg <= sidew1_reg;
        end
    end

    // ---------------- square root, one root bit per cell
    logic            vq_w   [0:SQ_STEPS];
    logic [SQ_W-1:0] rem_w  [0:SQ_STEPS];
    logic [SQ_W-1:0] root_w [0:SQ_STEPS];
    logic [SQS-1:0]  sq_w   [0:SQ_STEPS];

    assign vq_w[0]   = vw2_reg;
    assign rem_w[0]  = SQ_W'(w_reg[CW-2:0]) << 30;
    assign root_w[0] = '0;
    assign sq_w[0]   = {sidew2_reg, clat2_reg, slat2_reg};

    generate
        for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
            e2g_sqrt_cell #(.SIDE_W(SQS), .K(SQ_STEPS - 1 - j)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vq_w[j]),
                .rem_in(rem_w[j]), .root_in(root_w[j]), .side_in(sq_w[j]),
                .out_valid(vq_w[j+1]), .rem_out(rem_w[j+1]), .root_out(root_w[j+1]),
                .side_out(sq_w[j+1])
            );
        end
    endgenerate

    // ---------------- height terms
    logic                 polarq, polarh;
    logic signed [W-1:0]  zq, pq, zh, tpc, tzs, taq;
    logic [ANGLE_W-1:0]   lonq, lonh;
    logic signed [AW-1:0] latq, lath;
    logic signed [CW-1:0] clatq, slatq, qroot;
    logic                 vh, vh2_unused, vh3_unused;

    assign {polarq, zq, lonq, pq, latq, clatq, slatq} = sq_w[SQ_STEPS];
    assign qroot = $signed({1'b0, root_w[SQ_STEPS][CW-2:0]});

    e2g_mulq #(.W(W), .SIDE_W(1 + ANGLE_W)) u_pc (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vq_w[SQ_STEPS]),
        .v_in(pq), .c_in(clatq), .side_in({polarq, lonq}),
        .out_valid(vh), .prod_out(tpc), .side_out({polarh, lonh})
    );

    e2g_mulq #(.W(W), .SIDE_W(W)) u_zs (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vq_w[SQ_STEPS]),
        .v_in(zq), .c_in(slatq), .side_in(zq),
        .out_valid(vh2_unused), .prod_out(tzs), .side_out(zh)
    );

    e2g_mulq #(.W(W), .SIDE_W(AW)) u_aq (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(vq_w[SQ_STEPS]),
        .v_in(A_INT), .c_in(qroot), .side_in(latq),
        .out_valid(vh3_unused), .prod_out(taq), .side_out(lath)
    );

    // ---------------- output row: polar override, rounding, saturation
    logic                  m_valid_reg, deg_reg, deg_next;
    logic [ANGLE_W-1:0]    lat_out_reg, lon_out_reg, lat_out_next, lon_out_next;
    logic [HEIGHT_W-1:0]   h_out_reg, h_out_next;
    logic signed [HW-1:0]  h_full, h_rnd;

    always_comb begin
        h_full       = HW'(tpc) + HW'(tzs) - HW'(taq);
        lat_out_next = lath[ANGLE_W-1:0];
        lon_out_next = lonh;
        deg_next     = 1'b0;
        if (polarh) begin
            lon_out_next = '0;
            deg_next     = 1'b1;
            if (zh > 0) begin
                lat_out_next = ANGLE_W'(QUARTER_TURN);
            end else if (zh < 0) begin
                lat_out_next = ANGLE_W'(-QUARTER_TURN);
            end else begin
                lat_out_next = '0;
            end
            h_full = (zh[W-1] ? -HW'(zh) : HW'(zh)) - HW'(B_INT);
        end
        h_rnd      = (h_full + H_HALF) >>> GUARD_BITS;
        h_out_next = h_rnd[HEIGHT_W-1:0];
        if (h_rnd > H_MAX) begin
            h_out_next = H_MAX[HEIGHT_W-1:0];
            deg_next   = 1'b1;
        end else if (h_rnd < H_MIN) begin
            h_out_next = H_MIN[HEIGHT_W-1:0];
            deg_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vh;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_out_reg <= lat_out_next;
            lon_out_reg <= lon_out_next;
            h_out_reg   <= h_out_next;
            deg_reg     <= deg_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2 * ANGLE_W - HEIGHT_W)'(0), h_out_reg,
                       lon_out_reg, lat_out_reg};
    assign m_tuser  = deg_reg;

endmodule

/* rtl/e2g_cordic_cell.sv */
module e2g_cordic_cell
    import e2g_pkg::*;
#(
    parameter int W      = 52,
    parameter int SIDE_W = 1,
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      x_in,
    input  logic signed [W-1:0]      y_in,
    input  logic signed [AW-1:0]     ang_in,
    input  logic        [SIDE_W-1:0] side_in,
    output logic                     out_valid,
    output logic signed [W-1:0]      x_out,
    output logic signed [W-1:0]      y_out,
    output logic signed [AW-1:0]     ang_out,
    output logic        [SIDE_W-1:0] side_out
);

    localparam logic signed [AW-1:0] STEP = AW'(step_angle(STAGE));

    logic                valid_reg;
    logic signed [W-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic [SIDE_W-1:0]   side_reg;
    logic                turn_neg;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        // vectoring drives y to zero, rotation drives the residual angle to zero
        turn_neg = VECTOR ? y_in[W-1] : !ang_in[AW-1];
        if (turn_neg) begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - STEP;
        end else begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign ang_out   = ang_reg;
    assign side_out  = side_reg;

endmodule

/* rtl/e2g_cordic_chain.sv */
module e2g_cordic_chain
    import e2g_pkg::*;
#(
    parameter int W      = 52,
    parameter int SIDE_W = 1,
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      x_in,
    input  logic signed [W-1:0]      y_in,
    input  logic signed [AW-1:0]     ang_in,
    input  logic        [SIDE_W-1:0] side_in,
    output logic                     out_valid,
    output logic signed [W-1:0]      x_out,
    output logic signed [W-1:0]      y_out,
    output logic signed [AW-1:0]     ang_out,
    output logic        [SIDE_W-1:0] side_out
);

    localparam logic signed [AW-1:0] QT = AW'(QUARTER_TURN);

    logic                 v_w   [0:STAGES];
    logic signed [W-1:0]  x_w   [0:STAGES];
    logic signed [W-1:0]  y_w   [0:STAGES];
    logic signed [AW-1:0] a_w   [0:STAGES];
    logic [SIDE_W-1:0]    s_w   [0:STAGES];

    generate
        if (VECTOR) begin : g_pre
            logic                 valid_reg;
            logic signed [W-1:0]  x_reg, y_reg, x_next, y_next;
            logic signed [AW-1:0] ang_reg, ang_next;
            logic [SIDE_W-1:0]    side_reg;

            // left half plane: turn by a quarter so the iterations converge
            always_comb begin
                x_next   = x_in;
                y_next   = y_in;
                ang_next = ang_in;
                if (x_in[W-1]) begin
                    if (!y_in[W-1]) begin
                        x_next   = y_in;
                        y_next   = -x_in;
                        ang_next = ang_in + QT;
                    end else begin
                        x_next   = -y_in;
                        y_next   = x_in;
                        ang_next = ang_in - QT;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg <= 1'b0;
                end else if (en) begin
                    valid_reg <= in_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    ang_reg  <= ang_next;
                    side_reg <= side_in;
                end
            end

            assign v_w[0] = valid_reg;
            assign x_w[0] = x_reg;
            assign y_w[0] = y_reg;
            assign a_w[0] = ang_reg;
            assign s_w[0] = side_reg;
        end else begin : g_nopre
            assign v_w[0] = in_valid;
            assign x_w[0] = x_in;
            assign y_w[0] = y_in;
            assign a_w[0] = ang_in;
            assign s_w[0] = side_in;
        end

        for (genvar i = 0; i < STAGES; i++) begin : g_cell
            e2g_cordic_cell #(
                .W(W), .SIDE_W(SIDE_W), .STAGE(i), .VECTOR(VECTOR)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(v_w[i]), .x_in(x_w[i]), .y_in(y_w[i]),
                .ang_in(a_w[i]), .side_in(s_w[i]),
                .out_valid(v_w[i+1]), .x_out(x_w[i+1]), .y_out(y_w[i+1]),
                .ang_out(a_w[i+1]), .side_out(s_w[i+1])
            );
        end
    endgenerate

    assign out_valid = v_w[STAGES];
    assign x_out     = x_w[STAGES];
    assign y_out     = y_w[STAGES];
    assign ang_out   = a_w[STAGES];
    assign side_out  = s_w[STAGES];

endmodule

/* rtl/e2g_mulq.sv */
module e2g_mulq
    import e2g_pkg::*;
#(
    parameter int W      = 52,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      v_in,
    input  logic signed [CW-1:0]     c_in,
    input  logic        [SIDE_W-1:0] side_in,
    output logic                     out_valid,
    output logic signed [W-1:0]      prod_out,
    output logic        [SIDE_W-1:0] side_out
);

    // floor(v * c / 2^30) in two partial products
    localparam int LO_W = 26;
    localparam int HI_W = W - LO_W;
    localparam int PW   = W + CW + 1;

    logic signed [LO_W:0]        lo;
    logic signed [HI_W-1:0]      hi;
    logic signed [LO_W+CW:0]     pp_lo_next, pp_lo_reg;
    logic signed [HI_W+CW-1:0]   pp_hi_next, pp_hi_reg;
    logic signed [PW-1:0]        full;
    logic                        v1_reg, v2_reg;
    logic [SIDE_W-1:0]           side1_reg, side2_reg;
    logic signed [W-1:0]         prod_reg;

    always_comb begin
        lo         = $signed({1'b0, v_in[LO_W-1:0]});
        hi         = v_in[W-1:LO_W];
        pp_lo_next = lo * c_in;
        pp_hi_next = hi * c_in;
        full       = (PW'(pp_hi_reg) <<< LO_W) + PW'(pp_lo_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            side1_reg <= side_in;
            prod_reg  <= full[W+29:30];
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign prod_out  = prod_reg;
    assign side_out  = side2_reg;

endmodule

/* rtl/e2g_sqrt_cell.sv */
module e2g_sqrt_cell
    import e2g_pkg::*;
#(
    parameter int SIDE_W = 1,
    parameter int K      = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   rem_in,
    input  logic [SQ_W-1:0]   root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [SQ_W-1:0]   rem_out,
    output logic [SQ_W-1:0]   root_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic              valid_reg;
    logic [SQ_W-1:0]   rem_reg, root_reg, rem_next, root_next, trial;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        trial = root_in + BIT;
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end else begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

/* rtl/e2g_checker.sv */
module e2g_checker
    import e2g_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // intake stops only while a result is stuck
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // latitude never passes a pole
    a_lat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[31:0]) >= -32'sd1073741824))
        else $error("latitude out of range");

endmodule

bind ecef_to_geodetic_convert e2g_checker u_e2g_checker (.*);

/* tb/sv/ecef_to_geodetic_convert_test.sv */
`timescale 1ns / 100ps

module ecef_to_geodetic_convert_test;
    import e2g_pkg::*;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  lat;
        logic signed [ANGLE_W-1:0]  lon;
        logic signed [HEIGHT_W-1:0] hgt;
        logic                       degen;
    } geo_t;

    class geo_scoreboard;
        geo_t   pending[$];
        int     errors;
        longint atan_tab[48];

        function new();
            longint head[10];
            head = '{536870912, 316933406, 167458907, 85004756, 42667331,
                     21354465, 10679838, 5340245, 2670163, 1335087};
            for (int i = 0; i < 48; i++)
                atan_tab[i] = (i < 10) ? head[i]
                            : (ANGLE_PER_RAD + (64'sd1 <<< (i - 1))) >>> i;
            errors = 0;
        endfunction

        function automatic longint fl(longint v, int s);
            if (s >= 63) return (v < 0) ? -1 : 0;
            return v >>> s;
        endfunction

        function automatic longint qmul(longint v, longint c);
            longint hi, lo;
            hi = fl(v, 30);
            lo = v - hi * Q30_ONE;
            return hi * c + fl(lo * c, 30);
        endfunction

        function automatic longint vectoring(longint xi, longint yi, output longint mag);
            longint x, y, ang, t, dx, dy;
            x = xi; y = yi; ang = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; ang = QUARTER_TURN;
                end else begin
                    x = -y; y = t; ang = -QUARTER_TURN;
                end
            end
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
                dx = fl(y, i); dy = fl(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; ang += atan_tab[i];
                end else begin
                    x -= dx; y += dy; ang -= atan_tab[i];
                end
            end
            mag = x;
            return ang;
        endfunction

        function automatic void sincos(longint ang, output longint c, output longint s);
            longint x, y, dx, dy;
            x = INV_GAIN_Q30; y = 0;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
                dx = fl(y, i); dy = fl(x, i);
                if (ang >= 0) begin
                    x -= dx; y += dy; ang -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; ang += atan_tab[i];
                end
            end
            c = x; s = y;
        endfunction

        function automatic longint cube(longint v);
            return fl(fl(v * v, 30) * v, 30);
        endfunction

        function automatic longint root(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function automatic geo_t convert(longint xp, longint yp, longint zp);
            geo_t   g;
            longint x, y, z, a_int, b_int, lat, lon, h, hr;
            longint p, dummy, th, cth, sth, num, den, clat, slat, s2, w, q;
            x = xp <<< GUARD_BITS; y = yp <<< GUARD_BITS; z = zp <<< GUARD_BITS;
            a_int = SEMI_MAJOR_M <<< (FRACTION_BITS_DEF + GUARD_BITS);
            b_int = qmul(a_int, B_OVER_A_Q30);
            g.degen = 0;
            if (x == 0 && y == 0) begin
                lon = 0;
                lat = (z > 0) ? QUARTER_TURN : ((z < 0) ? -QUARTER_TURN : 0);
                h = ((z < 0) ? -z : z) - b_int;
                g.degen = 1;
            end else begin
                lon = vectoring(x, y, p);
                p = qmul(p, INV_GAIN_Q30);
                th = vectoring(qmul(p, B_OVER_A_Q30), z, dummy);
                sincos(th, cth, sth);
                num = z + qmul(qmul(b_int, EP2_Q30), cube(sth));
                den = p - qmul(qmul(a_int, E2_Q30), cube(cth));
                lat = vectoring(den, num, dummy);
                if (lat > QUARTER_TURN) lat = QUARTER_TURN;
                if (lat < -QUARTER_TURN) lat = -QUARTER_TURN;
                sincos(lat, clat, slat);
                s2 = fl(slat * slat, 30);
                w = Q30_ONE - fl(s2 * E2_Q30, 30);
                if (w < 0) w = 0;
                q = root(longint'(w) << 30);
                h = qmul(p, clat) + qmul(z, slat) - qmul(a_int, q);
            end
            hr = fl(h + (64'sd1 <<< (GUARD_BITS - 1)), GUARD_BITS);
            if (hr > HEIGHT_MAX) begin
                hr = HEIGHT_MAX; g.degen = 1;
            end
            if (hr < HEIGHT_MIN) begin
                hr = HEIGHT_MIN; g.degen = 1;
            end
            g.lat = lat[ANGLE_W-1:0];
            g.lon = lon[ANGLE_W-1:0];
            g.hgt = hr[HEIGHT_W-1:0];
            return g;
        endfunction

        function void note_position(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                    logic signed [POS_W-1:0] z);
            pending.push_back(convert(x, y, z));
        endfunction

        function void check_result(geo_t got);
            geo_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat lat=%0d lon=%0d h=%0d f=%0b",
                         $time, got.lat, got.lon, got.hgt, got.degen);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.lat !== want.lat) begin
                $display("%0t: latitude exp %0d got %0d", $time, want.lat, got.lat);
                errors++;
            end
            if (got.lon !== want.lon) begin
                $display("%0t: longitude exp %0d got %0d", $time, want.lon, got.lon);
                errors++;
            end
            if (got.hgt !== want.hgt) begin
                $display("%0t: height exp %0d got %0d", $time, want.hgt, got.hgt);
                errors++;
            end
            if (got.degen !== want.degen) begin
                $display("%0t: degenerate exp %0b got %0b", $time, want.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    localparam longint PMAX = 64'sd17179869183;
    localparam longint PMIN = -64'sd17179869184;
    localparam longint EARTH = 64'sd7200000000;  // ~7000 km in metres * 1024

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    geo_scoreboard sb = new();
    longint        cycles = 0;
    bit            sending_done = 0;
    bit            no_gaps = 0;

    ecef_to_geodetic_convert dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_position(s_tdata[34:0], s_tdata[69:35], s_tdata[104:70]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[31:0], m_tdata[63:32], m_tdata[98:64], m_tuser});
    end

    // receiver: random stall before each beat
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge aclk) m_tready <= 0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic longint rnd_full();
        return longint'({$urandom, $urandom}) >>> 29;
    endfunction

    function automatic longint rnd_span(longint lim);
        return longint'({$urandom, $urandom} % (2 * lim + 1)) - lim;
    endfunction

    task automatic send_position(longint x, longint y, longint z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'd0, z[34:0], y[34:0], x[34:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        longint ex[19], ey[19], ez[19];
        int sel;
        ex = '{0, 0, 0, 0, 0, PMAX, PMIN, PMAX, PMIN, -1, 1, 64'sd6531212288, 0,
               -64'sd6531212288, 64'sd4618000000, 1, 0, 64'sd1000, -64'sd5000};
        ey = '{0, 0, 0, 0, 0, PMAX, PMIN, PMIN, PMAX, 0, -1, 0, 64'sd6531212288,
               -5, 64'sd4618000000, 0, -1, -64'sd1000, 64'sd3};
        ez = '{0, 1, -1, PMAX, PMIN, PMAX, PMIN, 0, PMAX, 0, 0, 0, 0, 0,
               64'sd4500000000, PMIN, PMAX, 64'sd6510000000, -64'sd6510000000};
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;
        for (int i = 0; i < 19; i++)
            send_position(ex[i], ey[i], ez[i]);
        for (int i = 0; i < 1750; i++) begin
            if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 5)       // near-surface and orbital points
                send_position(rnd_span(EARTH), rnd_span(EARTH), rnd_span(EARTH));
            else if (sel < 7)
                send_position(rnd_full(), rnd_full(), rnd_full());
            else if (sel == 7) // polar axis
                send_position(0, 0, rnd_full());
            else if (sel == 8) // deep inside the ellipsoid
                send_position(rnd_span(100000), rnd_span(100000), rnd_span(EARTH));
            else
                send_position(rnd_span(EARTH), 0, rnd_span(1000));
        end
        s_tvalid <= 0;
        no_gaps = 0;
        sending_done = 1;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (230) @(posedge aclk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
